>>> rtl/mcro_pkg.sv
`default_nettype none

package mcro_pkg;

   // Widest cursor row the block handles, in pixels.
   localparam int MAX_WIDTH = 64;
   // Width of the image_width register.
   localparam int WIDTH_W = 7;
   localparam logic [WIDTH_W-1:0] RESET_WIDTH = WIDTH_W'(32);

   // Pixels per outline lane, and the lane count that covers one row.
   localparam int LANE_PIX = 8;
   localparam int LANES = MAX_WIDTH / LANE_PIX;
   // A lane sees one extra pixel on each side of its slice.
   localparam int HALO_W = LANE_PIX + 2;

   // Result queue: a row transaction may push two results at once.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [MAX_WIDTH-1:0] row_type;

   typedef struct packed {
      row_type opaque;
      row_type white;
      logic    last;
   } rsp_type;

   // Results produced by one accepted row, in output order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   // Pixels at or above the width are masked; widths above the row saturate.
   function automatic row_type width_mask(logic [WIDTH_W-1:0] w);
      row_type m;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         m[i] = (int'(w) > i);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> rtl/mcro_lane.sv
`default_nettype none

// Outlines one slice of a row. Index 0 of the halo inputs is the pixel left of
// the slice, index HALO_W-1 the pixel right of it.
module mcro_lane (
   input  wire logic [mcro_pkg::HALO_W-1:0]   up_op,
   input  wire logic [mcro_pkg::HALO_W-1:0]   mid_op,
   input  wire logic [mcro_pkg::HALO_W-1:0]   low_op,
   input  wire logic [mcro_pkg::LANE_PIX-1:0] mid_wh,
   input  wire logic [mcro_pkg::LANE_PIX-1:0] mask,
   output logic      [mcro_pkg::LANE_PIX-1:0] opaque,
   output logic      [mcro_pkg::LANE_PIX-1:0] white
);

   logic [mcro_pkg::HALO_W-1:0] any_op;

   always_comb begin
      any_op = up_op | mid_op | low_op;
      for (int i = 0; i < mcro_pkg::LANE_PIX; i++) begin
         opaque[i] = (mid_op[i+1] | up_op[i+1] | low_op[i+1] | any_op[i] | any_op[i+2])
                     & mask[i];
         white[i]  = mid_wh[i] & mid_op[i+1] & mask[i];
      end
   end

endmodule

`default_nettype wire

>>> rtl/mcro_outq.sv
`default_nettype none

// Small result queue that takes up to two results per cycle and hands out one.
module mcro_outq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mcro_pkg::push_type push,
   output logic                    room,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output mcro_pkg::rsp_type       rsp_data
);

   mcro_pkg::rsp_type mem_ff [mcro_pkg::QUEUE_DEPTH];

   logic [mcro_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mcro_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mcro_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        pop;

   always_comb begin
      rsp_valid = (count_ff != '0);
      rsp_data  = mem_ff[rd_ptr_ff];
      // Room for two results leaves a worst case row transaction safe.
      room      = (count_ff <= mcro_pkg::QCNT_W'(mcro_pkg::QUEUE_DEPTH - 2));
      pop       = rsp_valid & rsp_ready;
      wr_ptr_in = wr_ptr_ff + mcro_pkg::QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + mcro_pkg::QPTR_W'(pop);
      count_in  = count_ff + mcro_pkg::QCNT_W'(push.count) - mcro_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + mcro_pkg::QPTR_W'(1)] <= push.second;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mono_cursor_mask_to_outlined_rgba_unit.sv
// A result is pushed into the queue by the row transaction that causes it;
// rows come out one row late and a last-marked row releases the held row and itself.
// Throughput: one row per cycle back to back. The first row of a multi-row image pushes
// no result and a last row two, so a result side taking one per cycle never fills the
// four-entry queue; req_ready drops only while more than two results wait.
// Reset (synchronous, active high) empties the window and queue and sets the width to 32.
`default_nettype none

module mono_cursor_mask_to_outlined_rgba_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Row input channel.
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [63:0]                   req_and_row,
   input  wire logic [63:0]                   req_xor_row,
   input  wire logic                          req_last_row,
   // Result channel.
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [63:0]                   rsp_opaque_row,
   output logic      [63:0]                   rsp_white_row,
   output logic                               rsp_row_last,
   // Width register write port.
   input  wire logic                          csr_write_enable,
   input  wire logic [mcro_pkg::WIDTH_W-1:0]  csr_write_data
);

   // The window holds the classified middle row and the opacity of the row
   // above it. All row values in the window are already width masked.
   logic [mcro_pkg::WIDTH_W-1:0] width_ff, width_in;
   mcro_pkg::row_type mid_op_ff, mid_op_in;
   mcro_pkg::row_type mid_wh_ff, mid_wh_in;
   mcro_pkg::row_type upper_ff, upper_in;
   logic              have_mid_ff, have_mid_in;

   logic              accept;
   mcro_pkg::row_type mask;
   mcro_pkg::row_type new_op;
   mcro_pkg::row_type new_wh;
   mcro_pkg::row_type upper_b;

   // Rows with a one-pixel border of zeros on each side for the lane halos.
   logic [mcro_pkg::MAX_WIDTH+1:0] ext_up_a, ext_mid_a, ext_low_a;
   logic [mcro_pkg::MAX_WIDTH+1:0] ext_up_b, ext_mid_b;

   mcro_pkg::row_type row_a_op, row_a_wh;
   mcro_pkg::row_type row_b_op, row_b_wh;
   mcro_pkg::rsp_type rsp_a, rsp_b, rsp_data;
   mcro_pkg::push_type push;
   logic              room;

   always_comb begin
      accept  = req_valid & req_ready;
      mask    = mcro_pkg::width_mask(width_ff);
      // An XOR bit makes the pixel white; a clear AND bit makes it black.
      new_wh  = req_xor_row & mask;
      new_op  = (req_xor_row | ~req_and_row) & mask;
      // The row above the incoming one, as seen by the flushed last row.
      upper_b = have_mid_ff ? mid_op_ff : '0;

      // Row A: the held row, with the incoming row below it.
      ext_up_a  = {1'b0, upper_ff, 1'b0};
      ext_mid_a = {1'b0, mid_op_ff, 1'b0};
      ext_low_a = {1'b0, new_op, 1'b0};
      // Row B: the incoming row when it is the last, with nothing below.
      ext_up_b  = {1'b0, upper_b, 1'b0};
      ext_mid_b = {1'b0, new_op, 1'b0};
   end

   // One outline lane per slice for each of the two candidate results.
   for (genvar k = 0; k < mcro_pkg::LANES; k++) begin : g_lane
      mcro_lane u_lane_a (
         .up_op  (ext_up_a[k*mcro_pkg::LANE_PIX +: mcro_pkg::HALO_W]),
         .mid_op (ext_mid_a[k*mcro_pkg::LANE_PIX +: mcro_pkg::HALO_W]),
         .low_op (ext_low_a[k*mcro_pkg::LANE_PIX +: mcro_pkg::HALO_W]),
         .mid_wh (mid_wh_ff[k*mcro_pkg::LANE_PIX +: mcro_pkg::LANE_PIX]),
         .mask   (mask[k*mcro_pkg::LANE_PIX +: mcro_pkg::LANE_PIX]),
         .opaque (row_a_op[k*mcro_pkg::LANE_PIX +: mcro_pkg::LANE_PIX]),
         .white  (row_a_wh[k*mcro_pkg::LANE_PIX +: mcro_pkg::LANE_PIX])
      );
      mcro_lane u_lane_b (
         .up_op  (ext_up_b[k*mcro_pkg::LANE_PIX +: mcro_pkg::HALO_W]),
         .mid_op (ext_mid_b[k*mcro_pkg::LANE_PIX +: mcro_pkg::HALO_W]),
         .low_op ('0),
         .mid_wh (new_wh[k*mcro_pkg::LANE_PIX +: mcro_pkg::LANE_PIX]),
         .mask   (mask[k*mcro_pkg::LANE_PIX +: mcro_pkg::LANE_PIX]),
         .opaque (row_b_op[k*mcro_pkg::LANE_PIX +: mcro_pkg::LANE_PIX]),
         .white  (row_b_wh[k*mcro_pkg::LANE_PIX +: mcro_pkg::LANE_PIX])
      );
   end

   // Merge the lane slices into whole rows and pick which results to push.
   // The held row goes first if there is one; the last row follows it.
   always_comb begin
      rsp_a.opaque = row_a_op;
      rsp_a.white  = row_a_wh;
      rsp_a.last   = 1'b0;
      rsp_b.opaque = row_b_op;
      rsp_b.white  = row_b_wh;
      rsp_b.last   = 1'b1;

      push.first  = have_mid_ff ? rsp_a : rsp_b;
      push.second = rsp_b;
      push.count  = accept ? (2'(have_mid_ff) + 2'(req_last_row)) : 2'd0;
   end

   // Window update. A last row returns the window to its empty state.
   always_comb begin
      width_in    = csr_write_enable ? csr_write_data : width_ff;
      have_mid_in = have_mid_ff;
      mid_op_in   = mid_op_ff;
      mid_wh_in   = mid_wh_ff;
      upper_in    = upper_ff;
      if (accept) begin
         have_mid_in = !req_last_row;
         mid_op_in   = req_last_row ? '0 : new_op;
         mid_wh_in   = req_last_row ? '0 : new_wh;
         upper_in    = req_last_row ? '0 : upper_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= mcro_pkg::RESET_WIDTH;
         have_mid_ff <= 1'b0;
         mid_op_ff   <= '0;
         mid_wh_ff   <= '0;
         upper_ff    <= '0;
      end else begin
         width_ff    <= width_in;
         have_mid_ff <= have_mid_in;
         mid_op_ff   <= mid_op_in;
         mid_wh_ff   <= mid_wh_in;
         upper_ff    <= upper_in;
      end
   end

   mcro_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A new row transaction is taken whenever the queue can absorb two results.
   assign req_ready      = room;
   assign rsp_opaque_row = rsp_data.opaque;
   assign rsp_white_row  = rsp_data.white;
   assign rsp_row_last   = rsp_data.last;

endmodule

`default_nettype wire

>>> rtl/mcro_checker.sv
`default_nettype none

module mcro_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last_row,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_opaque_row,
   input wire logic [63:0] rsp_white_row
);

   // A white pixel is always an opaque pixel.
   a_white_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_white_row & ~rsp_opaque_row) == 64'd0))
      else $error("white pixel without opacity");

   // A last-marked row always produces at least one result right away.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_row) |=> rsp_valid)
      else $error("last row gave no result");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn while stalled");

endmodule

bind mono_cursor_mask_to_outlined_rgba_unit mcro_checker u_mcro_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_last_row   (req_last_row),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_opaque_row (rsp_opaque_row),
   .rsp_white_row  (rsp_white_row)
);

`default_nettype wire

>>> dv/mono_cursor_mask_to_outlined_rgba_unit_tb.sv
`timescale 1ns / 1ps

module mono_cursor_mask_to_outlined_rgba_unit_tb;

   import mcro_pkg::*;

   // Cycles without any transaction on either channel before the run is abandoned.
   localparam int STALL_LIMIT = 2000;
   localparam int ROW_TARGET = 1500;
   localparam row_type ALL_ONES = '1;

   // Models the row window of the block and keeps the outlined rows that are
   // still owed by the result channel, oldest first.
   class cursor_outline_scoreboard;
      row_type            held_opaque;
      row_type            held_white;
      row_type            above_opaque;
      bit                 held_valid;
      logic [WIDTH_W-1:0] image_width;
      rsp_type            owed_rows[$];
      int unsigned        errors;
      int unsigned        rows_in;
      int unsigned        rows_out;

      function new();
         image_width = RESET_WIDTH;
         errors = 0;
         rows_in = 0;
         rows_out = 0;
         clear_window();
      endfunction

      function void clear_window();
         held_opaque = '0;
         held_white = '0;
         above_opaque = '0;
         held_valid = 1'b0;
      endfunction

      function void set_width(logic [WIDTH_W-1:0] w);
         image_width = w;
      endfunction

      // Widths of 64 and above keep the whole row.
      function row_type visible_pixels();
         if (image_width >= 64) begin
            return ALL_ONES;
         end
         return (row_type'(1) << image_width) - row_type'(1);
      endfunction

      // A transparent pixel next to an opaque one, in any of the eight
      // directions, turns into a black outline pixel.
      function rsp_type outline_row(row_type up, row_type mid_op, row_type mid_wh,
                                    row_type low, logic last);
         rsp_type r;
         row_type m;
         row_type any_op;
         row_type near_op;
         m = visible_pixels();
         any_op = up | mid_op | low;
         near_op = up | low | (any_op << 1) | (any_op >> 1);
         r.opaque = (mid_op | near_op) & m;
         r.white = mid_wh & mid_op & m;
         r.last = last;
         return r;
      endfunction

      function int unsigned pending();
         return owed_rows.size();
      endfunction

      function void note_row(row_type and_in, row_type xor_in, logic last);
         row_type m;
         row_type xor_vis;
         row_type entry_opaque;
         m = visible_pixels();
         xor_vis = xor_in & m;
         entry_opaque = (xor_vis | ~(and_in & m)) & m;
         rows_in++;
         if (held_valid) begin
            owed_rows.push_back(outline_row(above_opaque, held_opaque, held_white,
                                            entry_opaque, 1'b0));
            above_opaque = held_opaque;
         end else begin
            above_opaque = '0;
         end
         held_opaque = entry_opaque;
         held_white = xor_vis;
         held_valid = 1'b1;
         if (last) begin
            owed_rows.push_back(outline_row(above_opaque, held_opaque, held_white,
                                            '0, 1'b1));
            clear_window();
         end
      endfunction

      function void check_row(row_type opaque, row_type white, logic last);
         rsp_type want;
         rows_out++;
         if (owed_rows.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected result row: opaque %h white %h last %b",
                        opaque, white, last);
            end
            return;
         end
         want = owed_rows.pop_front();
         if (want.opaque !== opaque || want.white !== white || want.last !== last) begin
            errors++;
            if (errors <= 10) begin
               $display("result row %0d: expected opaque %h white %h last %b",
                        rows_out, want.opaque, want.white, want.last);
               $display("result row %0d: got      opaque %h white %h last %b",
                        rows_out, opaque, white, last);
            end
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   row_type            req_and_row;
   row_type            req_xor_row;
   logic               req_last_row;
   logic               rsp_valid;
   logic               rsp_ready;
   row_type            rsp_opaque_row;
   row_type            rsp_white_row;
   logic               rsp_row_last;
   logic               csr_write_enable;
   logic [WIDTH_W-1:0] csr_write_data;

   cursor_outline_scoreboard sb;
   // When clear, both sides run with no gaps and no stalls.
   bit                       idle_on;
   int unsigned              quiet_cycles;
   int unsigned              width_writes;

   mono_cursor_mask_to_outlined_rgba_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_and_row      (req_and_row),
      .req_xor_row      (req_xor_row),
      .req_last_row     (req_last_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_opaque_row   (rsp_opaque_row),
      .rsp_white_row    (rsp_white_row),
      .rsp_row_last     (rsp_row_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Both channels are observed at the rising edge, where the block's own
   // updates have not yet landed, so the sampled values are the settled ones.
   // The watchdog counts cycles in which no transaction moves on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_row(req_and_row, req_xor_row, req_last_row);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_row(rsp_opaque_row, rsp_white_row, rsp_row_last);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d rows still owed",
                     STALL_LIMIT, sb.pending());
            $display("mono_cursor_mask_to_outlined_rgba_unit_tb: errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Result side: with idle_on set it may hold ready low for a random number of cycles
   // before each transaction; it then keeps ready high until a result is taken.
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      repeat (8) @(negedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Called at a falling edge. Leaves valid high after the transaction; the
   // next call or drop_rows decides at that same edge what happens to it, so
   // valid is assigned once per time step.
   task automatic send_row(row_type and_in, row_type xor_in, logic last);
      int gap;
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_and_row <= and_in;
      req_xor_row <= xor_in;
      req_last_row <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drop_rows();
      req_valid <= 1'b0;
   endtask

   // The width register is only touched with the result channel drained. A
   // row that caused no result may still be held in the block at the write.
   task automatic write_width(logic [WIDTH_W-1:0] w);
      drop_rows();
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= w;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data <= WIDTH_W'($urandom_range(0, 127));
      sb.set_width(w);
      width_writes++;
   endtask

   function automatic row_type random_row();
      return {$urandom, $urandom};
   endfunction

   // AND rows lean toward ones so that transparent runs are common; XOR rows
   // lean toward sparse so that outlines have room to form.
   function automatic row_type random_and_row();
      case ($urandom_range(0, 4))
         0: return random_row();
         1: return random_row() | random_row();
         2: return random_row() | random_row() | random_row();
         3: return ALL_ONES;
         default: return ~(row_type'(1) << $urandom_range(0, 63));
      endcase
   endfunction

   function automatic row_type random_xor_row();
      case ($urandom_range(0, 4))
         0: return random_row();
         1: return random_row() & random_row();
         2: return random_row() & random_row() & random_row();
         3: return '0;
         default: return row_type'(1) << $urandom_range(0, 63);
      endcase
   endfunction

   // Extremes and row-size boundaries come up often; zero and widths past 64
   // also stand in the mix.
   function automatic logic [WIDTH_W-1:0] random_width();
      case ($urandom_range(0, 12))
         0: return WIDTH_W'(0);
         1: return WIDTH_W'(1);
         2: return WIDTH_W'(2);
         3: return WIDTH_W'(7);
         4: return WIDTH_W'(8);
         5: return WIDTH_W'(31);
         6: return WIDTH_W'(33);
         7: return WIDTH_W'(63);
         8: return WIDTH_W'(64);
         9: return WIDTH_W'(65);
         10: return WIDTH_W'(127);
         default: return WIDTH_W'($urandom_range(1, 64));
      endcase
   endfunction

   initial begin
      int images;
      int rows;
      bit cut_short;
      sb = new();
      idle_on = 1'b0;
      quiet_cycles = 0;
      width_writes = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_and_row <= '0;
      req_xor_row <= '0;
      req_last_row <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows at the reset width of 32. Single-row images come first:
      // one all transparent, one all black, where bits past the width must
      // vanish.
      send_row(ALL_ONES, '0, 1'b1);
      send_row('0, '0, 1'b1);
      // A three-row image with one black and one white pixel in the middle row
      // and XOR bits that sit entirely above the width.
      send_row(ALL_ONES, '0, 1'b0);
      send_row(~(row_type'(1) << 5), (row_type'(1) << 20) | 64'hFFFF_0000_0000_0000,
               1'b0);
      send_row(ALL_ONES, '0, 1'b1);
      // XOR set wins whatever the AND bit says.
      send_row('0, ALL_ONES, 1'b1);
      send_row(ALL_ONES, ALL_ONES, 1'b1);

      // Full width: outlines must stop at pixel 0 and pixel 63.
      write_width(7'd64);
      send_row(~row_type'(1), '0, 1'b0);
      send_row(ALL_ONES, row_type'(1) << 63, 1'b0);
      send_row(ALL_ONES, '0, 1'b1);

      // One pixel wide.
      write_width(7'd1);
      send_row(ALL_ONES, '0, 1'b0);
      send_row(~row_type'(1), '0, 1'b1);

      // Zero width clears everything.
      write_width(7'd0);
      send_row('0, ALL_ONES, 1'b0);
      send_row('0, ALL_ONES, 1'b1);

      // A width above the row saturates; then the width drops while a row is
      // held, and the held row's outline is masked again on the way out.
      write_width(7'd127);
      send_row(~(row_type'(1) << 40), '0, 1'b0);
      write_width(7'd8);
      send_row(64'hFFFF_FFFF_FFFF_FF7F, row_type'(1) << 9, 1'b1);

      // Random phases: a width, an idling mode, then a few images. Now and
      // then a phase stops before its last row, so the next width lands in the
      // middle of an image.
      while (sb.rows_in < ROW_TARGET) begin
         write_width(random_width());
         idle_on = ($urandom_range(0, 3) != 0);
         images = $urandom_range(1, 6);
         for (int i = 0; i < images; i++) begin
            rows = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 8);
            cut_short = (i == images - 1) && ($urandom_range(0, 4) == 0);
            for (int r = 0; r < rows; r++) begin
               send_row(random_and_row(), random_xor_row(),
                        (r == rows - 1) && !cut_short);
            end
         end
      end

      drop_rows();
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("covered %0d cursor rows and %0d outlined result rows over %0d width writes",
               sb.rows_in, sb.rows_out, width_writes);
      $display("mismatches %0d, rows still owed %0d", sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("mono_cursor_mask_to_outlined_rgba_unit_tb: clean");
      end else begin
         $display("mono_cursor_mask_to_outlined_rgba_unit_tb: errors");
      end
      $finish;
   end

endmodule
